/* hw/rtl/btncc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package btncc_pkg;

    localparam int IDX_W  = 3;
    localparam int TICK_W = 32;
    localparam int MASK_W = 8;
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] REG_RELEASE_MASK     = 3'd0;
    localparam logic [CFG_AW-1:0] REG_HELD_ENABLE_MASK = 3'd1;
    localparam logic [CFG_AW-1:0] REG_CLICK_TIMEOUT    = 3'd2;
    localparam logic [CFG_AW-1:0] REG_DOUBLE_TIMEOUT   = 3'd3;
    localparam logic [CFG_AW-1:0] REG_LONG_CLICK_MIN   = 3'd4;
    localparam logic [CFG_AW-1:0] REG_REPEAT_START     = 3'd5;
    localparam logic [CFG_AW-1:0] REG_REPEAT_INTERVAL  = 3'd6;

    // item kinds
    localparam logic CMD_LEVEL = 1'b0;
    localparam logic CMD_HELD  = 1'b1;

    // timing thresholds
    typedef struct packed {
        logic [TICK_W-1:0] click_timeout;
        logic [TICK_W-1:0] double_timeout;
        logic [TICK_W-1:0] long_click_min;
        logic [TICK_W-1:0] repeat_start;
        logic [TICK_W-1:0] repeat_interval;
    } t_timing;

    // per button time stamps, one memory word
    typedef struct packed {
        logic [TICK_W-1:0] click_time;
        logic [TICK_W-1:0] repeat_time;
        logic [TICK_W-1:0] press_time;
    } t_times;

    // result flags, pressed in the lowest bit
    typedef struct packed {
        logic activity;
        logic held_repeat;
        logic long_clicked;
        logic double_clicked;
        logic clicked;
        logic released;
        logic pressed;
    } t_result;

    typedef struct packed {
        logic              cmd;
        logic              pin_level;
        logic [TICK_W-1:0] now;
        logic              rel_level;
        logic              held_en;
        logic              seen;
        logic              level;
        t_times            times;
    } t_cls_in;

    typedef struct packed {
        t_result res;
        logic    seen;
        logic    level;
        t_times  times;
    } t_cls_out;

endpackage

`default_nettype wire

/* hw/rtl/btncc_classify.sv */
`timescale 1ns / 1ps
`default_nettype none

module btncc_classify (
    input  var btncc_pkg::t_timing  i_timing,
    input  var btncc_pkg::t_cls_in  i_cls,
    output var btncc_pkg::t_cls_out o_cls
);

    logic                          eff_level;
    logic                          go;
    logic [btncc_pkg::TICK_W-1:0] down_dt;
    logic [btncc_pkg::TICK_W-1:0] click_dt;
    logic [btncc_pkg::TICK_W-1:0] repeat_dt;

    // tick differences, wrapping
    assign down_dt   = i_cls.now - i_cls.times.press_time;
    assign click_dt  = i_cls.now - i_cls.times.click_time;
    assign repeat_dt = i_cls.now - i_cls.times.repeat_time;

    // before the first event the button counts as released
    assign eff_level = i_cls.seen ? i_cls.level : i_cls.rel_level;
    assign go        = (i_cls.pin_level != eff_level);

    // classify the item and build the next state
    always_comb begin
        o_cls       = '0;
        o_cls.seen  = i_cls.seen;
        o_cls.level = i_cls.level;
        o_cls.times = i_cls.times;
        if (i_cls.cmd == btncc_pkg::CMD_LEVEL) begin
            o_cls.seen = 1'b1;
            if (!go) begin
                o_cls.level = eff_level;
            end else if (eff_level == i_cls.rel_level) begin
                o_cls.level             = ~i_cls.rel_level;
                o_cls.times.press_time  = i_cls.now;
                o_cls.times.repeat_time = i_cls.now;
                o_cls.res.pressed       = 1'b1;
                o_cls.res.activity      = 1'b1;
            end else begin
                o_cls.level        = i_cls.rel_level;
                o_cls.res.released = 1'b1;
                o_cls.res.activity = 1'b1;
                if (down_dt < i_timing.click_timeout) begin
                    o_cls.res.clicked      = 1'b1;
                    o_cls.res.double_clicked = (click_dt < i_timing.double_timeout);
                    o_cls.times.click_time = i_cls.now;
                end else if (down_dt > i_timing.long_click_min) begin
                    o_cls.res.long_clicked = 1'b1;
                end
            end
        end else begin
            if (i_cls.seen && (i_cls.level != i_cls.rel_level) && i_cls.held_en &&
                (down_dt >= i_timing.repeat_start) &&
                (repeat_dt >= i_timing.repeat_interval)) begin
                o_cls.times.repeat_time = i_cls.now;
                o_cls.res.held_repeat   = 1'b1;
                o_cls.res.activity      = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/button_click_classifier_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Click classifier for up to BTN_COUNT pushbuttons. Each input beat is a
// pin level event or a held repeat check for one button, stamped with a
// wrapping 32-bit tick count; each beat yields exactly one result beat with
// press, release, click, double click, long click, held repeat and activity
// flags (all zero when nothing happened). One beat is taken every clock
// cycle while the result side does not stall; the beat passes through the
// stage 1 registers into the result register, and a stalled result holds
// the item behind it. The press, repeat and click times of all buttons sit
// in one memory with one read port and one write port: the entry is read
// when a beat is accepted and written back when that beat moves into the
// result register, and a beat for the same button accepted at that same
// edge picks up the written value through a bypass register. Entries start
// at zero after reset through per-entry valid flags, so no clearing pass is
// needed. Configuration may be written only while no beat is in flight.
module button_click_classifier_top #(
    parameter int BTN_COUNT = 8
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    // input beat
    input  wire                             i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [2:0] button_index, [3] pin_level, [35:4] now_ticks, [39:36] zero
    input  wire  [39:0]                     i_s_axis_tdata,
    // [0] cmd
    input  wire                             i_s_axis_tuser,
    // result beat
    output logic                            o_m_axis_tvalid,
    input  wire                             i_m_axis_tready,
    // [0] pressed, [1] released, [2] clicked, [3] double_clicked,
    // [4] long_clicked, [5] held_repeat, [6] activity, [7] zero
    output logic [7:0]                      o_m_axis_tdata,
    // configuration writes
    input  wire                             i_cfg_we,
    input  wire  [btncc_pkg::CFG_AW-1:0]    i_cfg_addr,
    input  wire  [btncc_pkg::CFG_DW-1:0]    i_cfg_wdata
);

    localparam int AW = (BTN_COUNT > 1) ? $clog2(BTN_COUNT) : 1;
    localparam int MEM_W = $bits(btncc_pkg::t_times);
    localparam logic [btncc_pkg::IDX_W+5:0] NB = (btncc_pkg::IDX_W + 6)'(BTN_COUNT);

    // configuration registers
    logic [btncc_pkg::MASK_W-1:0] r_up_mask;
    logic [btncc_pkg::MASK_W-1:0] r_held_mask;
    btncc_pkg::t_timing           r_timing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_mask                <= 8'hFF;
            r_held_mask              <= 8'h00;
            r_timing.click_timeout   <= 32'd500;
            r_timing.double_timeout  <= 32'd400;
            r_timing.long_click_min  <= 32'd1000;
            r_timing.repeat_start    <= 32'd1000;
            r_timing.repeat_interval <= 32'd200;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                btncc_pkg::REG_RELEASE_MASK: begin
                    r_up_mask <= i_cfg_wdata[btncc_pkg::MASK_W-1:0];
                end
                btncc_pkg::REG_HELD_ENABLE_MASK: begin
                    r_held_mask <= i_cfg_wdata[btncc_pkg::MASK_W-1:0];
                end
                btncc_pkg::REG_CLICK_TIMEOUT:   r_timing.click_timeout   <= i_cfg_wdata;
                btncc_pkg::REG_DOUBLE_TIMEOUT:  r_timing.double_timeout  <= i_cfg_wdata;
                btncc_pkg::REG_LONG_CLICK_MIN:  r_timing.long_click_min  <= i_cfg_wdata;
                btncc_pkg::REG_REPEAT_START:    r_timing.repeat_start    <= i_cfg_wdata;
                btncc_pkg::REG_REPEAT_INTERVAL: r_timing.repeat_interval <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // input beat fields
    logic [btncc_pkg::IDX_W-1:0]  in_idx;
    logic                         in_lvl;
    logic [btncc_pkg::TICK_W-1:0] in_now;
    logic [AW-1:0]                in_addr;

    assign in_idx  = i_s_axis_tdata[2:0];
    assign in_lvl  = i_s_axis_tdata[3];
    assign in_now  = i_s_axis_tdata[35:4];
    assign in_addr = AW'(in_idx);

    // stage 1 registers: item waiting for its memory word
    logic                         r_s1_valid;
    logic                         r_s1_cmd;
    logic [btncc_pkg::IDX_W-1:0]  r_s1_idx;
    logic                         r_s1_lvl;
    logic [btncc_pkg::TICK_W-1:0] r_s1_now;
    logic [AW-1:0]                r_s1_addr;

    logic r_out_valid;
    btncc_pkg::t_result r_out;

    logic out_free;
    logic s1_adv;
    logic in_acc;
    logic s1_in_range;
    logic wr_en;

    // handshake
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign s1_adv          = r_s1_valid && out_free;
    assign o_s_axis_tready = !r_s1_valid || out_free;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign s1_in_range     = ({6'd0, r_s1_idx} < NB);
    assign wr_en           = s1_adv && s1_in_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_cmd  <= i_s_axis_tuser;
            r_s1_idx  <= in_idx;
            r_s1_lvl  <= in_lvl;
            r_s1_now  <= in_now;
            r_s1_addr <= in_addr;
        end
    end

    // time stamp memory, read at acceptance, written back from stage 1
    logic [MEM_W-1:0] mem [BTN_COUNT];
    logic [MEM_W-1:0] r_rdata;
    btncc_pkg::t_times wr_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_s1_addr] <= wr_data;
        end
        if (in_acc) begin
            r_rdata <= mem[in_addr];
        end
    end

    // bypass of a write landing on the entry being read
    logic              r_fwd_hit;
    btncc_pkg::t_times r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else if (in_acc) begin
            r_fwd_hit <= wr_en && (r_s1_addr == in_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_fwd_data <= wr_data;
        end
    end

    // per button flags: entry valid, seen first event, stored level
    logic [BTN_COUNT-1:0] r_valid;
    logic [BTN_COUNT-1:0] r_seen;
    logic [BTN_COUNT-1:0] r_level;

    btncc_pkg::t_cls_in  cls_in;
    btncc_pkg::t_cls_out cls_out;
    btncc_pkg::t_times   rd_times;

    // effective stored word: bypass, memory, or zero if never written
    always_comb begin
        if (r_fwd_hit) begin
            rd_times = r_fwd_data;
        end else if (r_valid[r_s1_addr]) begin
            rd_times = btncc_pkg::t_times'(r_rdata);
        end else begin
            rd_times = '0;
        end
    end

    always_comb begin
        cls_in.cmd       = r_s1_cmd;
        cls_in.pin_level = r_s1_lvl;
        cls_in.now       = r_s1_now;
        cls_in.rel_level = r_up_mask[r_s1_idx];
        cls_in.held_en   = r_held_mask[r_s1_idx];
        cls_in.seen      = r_seen[r_s1_addr];
        cls_in.level     = r_level[r_s1_addr];
        cls_in.times     = rd_times;
    end

    btncc_classify u_classify (
        .i_timing (r_timing),
        .i_cls    (cls_in),
        .o_cls    (cls_out)
    );

    assign wr_data = cls_out.times;

    // flag updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_seen  <= '0;
            r_level <= '0;
        end else if (wr_en) begin
            r_valid[r_s1_addr] <= 1'b1;
            r_seen[r_s1_addr]  <= cls_out.seen;
            r_level[r_s1_addr] <= cls_out.level;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= s1_in_range ? cls_out.res : '0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out};

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 400000;

    // one input beat before packing
    typedef struct packed {
        logic                         cmd;
        logic [btncc_pkg::IDX_W-1:0]  btn;
        logic                         lvl;
        logic [btncc_pkg::TICK_W-1:0] stamp;
    } t_click_beat;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_s_axis_tvalid = 1'b0;
    logic                         o_s_axis_tready;
    logic [39:0]                  i_s_axis_tdata = '0;
    logic                         i_s_axis_tuser = 1'b0;
    logic                         o_m_axis_tvalid;
    logic                         i_m_axis_tready = 1'b0;
    logic [7:0]                   o_m_axis_tdata;
    logic                         i_cfg_we = 1'b0;
    logic [btncc_pkg::CFG_AW-1:0] i_cfg_addr = '0;
    logic [btncc_pkg::CFG_DW-1:0] i_cfg_wdata = '0;

    // shadow configuration, reset values
    logic [btncc_pkg::MASK_W-1:0] cfg_up_mask   = 8'hFF;
    logic [btncc_pkg::MASK_W-1:0] cfg_held_en   = 8'h00;
    logic [btncc_pkg::TICK_W-1:0] cfg_click_to  = 32'd500;
    logic [btncc_pkg::TICK_W-1:0] cfg_double_to = 32'd400;
    logic [btncc_pkg::TICK_W-1:0] cfg_long_min  = 32'd1000;
    logic [btncc_pkg::TICK_W-1:0] cfg_rpt_start = 32'd1000;
    logic [btncc_pkg::TICK_W-1:0] cfg_rpt_gap   = 32'd200;

    // shadow per-button state
    bit                         btn_level    [8];
    bit                         btn_seen     [8];
    bit [btncc_pkg::TICK_W-1:0] btn_press_t  [8];
    bit [btncc_pkg::TICK_W-1:0] btn_repeat_t [8];
    bit [btncc_pkg::TICK_W-1:0] btn_click_t  [8];

    t_click_beat          beats_to_send [$];
    btncc_pkg::t_result   flags_due [$];

    int          mismatches = 0;
    int          beats_queued = 0;
    int          beats_taken = 0;
    int          results_seen = 0;
    int          cycles = 0;
    int          in_gap = 0;
    int          out_gap = 0;
    int          hold_left = 0;
    int          gap_pct_in = 0;
    int          gap_pct_out = 0;
    int          n_press = 0, n_click = 0, n_double = 0, n_long = 0, n_repeat = 0;
    logic [btncc_pkg::TICK_W-1:0] tick = '0;

    button_click_classifier_top #(
        .BTN_COUNT(8)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    // clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // classify one beat and advance the shadow state
    function automatic btncc_pkg::t_result classify_click(
            input logic cmd, input logic [btncc_pkg::IDX_W-1:0] b,
            input logic lvl, input logic [btncc_pkg::TICK_W-1:0] t);
        btncc_pkg::t_result           res;
        logic                         up;
        logic                         go;
        logic [btncc_pkg::TICK_W-1:0] down_dt;
        logic [btncc_pkg::TICK_W-1:0] since_click;
        logic [btncc_pkg::TICK_W-1:0] since_press;
        logic [btncc_pkg::TICK_W-1:0] since_repeat;
        res = '0;
        up = cfg_up_mask[b];
        if (cmd == btncc_pkg::CMD_LEVEL) begin
            go = 1'b1;
            if (btn_seen[b]) begin
                if (lvl == btn_level[b])
                    go = 1'b0;
            end else begin
                btn_seen[b] = 1'b1;
                if (lvl == up) begin
                    btn_level[b] = up;
                    go = 1'b0;
                end else begin
                    btn_level[b] = ~lvl;
                end
            end
            if (go) begin
                if (btn_level[b] == up) begin
                    btn_level[b] = ~up;
                    btn_press_t[b] = t;
                    btn_repeat_t[b] = t;
                    res.pressed = 1'b1;
                end else begin
                    down_dt = t - btn_press_t[b];
                    btn_level[b] = up;
                    res.released = 1'b1;
                    if (down_dt < cfg_click_to) begin
                        res.clicked = 1'b1;
                        since_click = t - btn_click_t[b];
                        if (since_click < cfg_double_to)
                            res.double_clicked = 1'b1;
                        btn_click_t[b] = t;
                    end else if (down_dt > cfg_long_min) begin
                        res.long_clicked = 1'b1;
                    end
                end
                res.activity = 1'b1;
            end
        end else if (btn_seen[b] && btn_level[b] != up && cfg_held_en[b]) begin
            since_press = t - btn_press_t[b];
            since_repeat = t - btn_repeat_t[b];
            if (since_press >= cfg_rpt_start && since_repeat >= cfg_rpt_gap) begin
                btn_repeat_t[b] = t;
                res.held_repeat = 1'b1;
                res.activity = 1'b1;
            end
        end
        return res;
    endfunction

    // sender: predicts on acceptance, then offers the next queued beat
    always @(posedge i_clk) begin : feed_proc
        t_click_beat it;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                flags_due.push_back(classify_click(i_s_axis_tuser, i_s_axis_tdata[2:0],
                                                   i_s_axis_tdata[3], i_s_axis_tdata[35:4]));
                beats_taken++;
            end
            if (i_s_axis_tvalid && !o_s_axis_tready) begin
                // hold the beat until taken
            end else if (in_gap > 0) begin
                in_gap--;
                i_s_axis_tvalid <= 1'b0;
            end else if (beats_to_send.size() > 0 && gap_pct_in > 0 &&
                         $urandom_range(99) < gap_pct_in) begin
                in_gap = $urandom_range(1, 12) - 1;
                i_s_axis_tvalid <= 1'b0;
            end else if (beats_to_send.size() > 0) begin
                it = beats_to_send.pop_front();
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata <= {4'd0, it.stamp, it.lvl, it.btn};
                i_s_axis_tuser <= it.cmd;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    task automatic check_flag(input string name, input logic want, input logic got);
        if (want !== got) begin
            $error("%s: expected %0b, got %0b", name, want, got);
            mismatches++;
        end
    endtask

    // receiver: compares each result beat, then decides on stalls
    always @(posedge i_clk) begin : watch_proc
        btncc_pkg::t_result got;
        btncc_pkg::t_result want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = btncc_pkg::t_result'(o_m_axis_tdata[6:0]);
                results_seen++;
                if (flags_due.size() == 0) begin
                    $error("result beat %h with nothing expected", o_m_axis_tdata);
                    mismatches++;
                end else begin
                    want = flags_due.pop_front();
                    check_flag("pressed", want.pressed, got.pressed);
                    check_flag("released", want.released, got.released);
                    check_flag("clicked", want.clicked, got.clicked);
                    check_flag("double_clicked", want.double_clicked, got.double_clicked);
                    check_flag("long_clicked", want.long_clicked, got.long_clicked);
                    check_flag("held_repeat", want.held_repeat, got.held_repeat);
                    check_flag("activity", want.activity, got.activity);
                    check_flag("pad", 1'b0, o_m_axis_tdata[7]);
                end
                n_press += got.pressed;
                n_click += got.clicked;
                n_double += got.double_clicked;
                n_long += got.long_clicked;
                n_repeat += got.held_repeat;
                // one long back-pressure stretch to fill the pipeline
                if (results_seen == 150)
                    hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else if (out_gap > 0) begin
                out_gap--;
                i_m_axis_tready <= 1'b0;
            end else if (gap_pct_out > 0 && $urandom_range(99) < gap_pct_out) begin
                out_gap = $urandom_range(1, 12) - 1;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL button_click_classifier_top");
            $finish;
        end
    end

    task automatic add_beat(input logic cmd, input logic [btncc_pkg::IDX_W-1:0] b,
                            input logic lvl, input logic [btncc_pkg::TICK_W-1:0] t);
        t_click_beat it;
        it.cmd = cmd;
        it.btn = b;
        it.lvl = lvl;
        it.stamp = t;
        beats_to_send.push_back(it);
        beats_queued++;
    endtask

    // wait until nothing is in flight, plus the pipeline depth
    task automatic drain_pipe();
        while (beats_to_send.size() != 0 || i_s_axis_tvalid || flags_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [7:0] up, input logic [7:0] held,
                              input logic [31:0] click_to, input logic [31:0] double_to,
                              input logic [31:0] long_min, input logic [31:0] rpt_start,
                              input logic [31:0] rpt_gap);
        logic [btncc_pkg::CFG_AW-1:0] idx  [7];
        logic [btncc_pkg::CFG_DW-1:0] vals [7];
        int k;
        idx[0] = btncc_pkg::REG_RELEASE_MASK;     vals[0] = {24'd0, up};
        idx[1] = btncc_pkg::REG_HELD_ENABLE_MASK; vals[1] = {24'd0, held};
        idx[2] = btncc_pkg::REG_CLICK_TIMEOUT;    vals[2] = click_to;
        idx[3] = btncc_pkg::REG_DOUBLE_TIMEOUT;   vals[3] = double_to;
        idx[4] = btncc_pkg::REG_LONG_CLICK_MIN;   vals[4] = long_min;
        idx[5] = btncc_pkg::REG_REPEAT_START;     vals[5] = rpt_start;
        idx[6] = btncc_pkg::REG_REPEAT_INTERVAL;  vals[6] = rpt_gap;
        for (k = 0; k < 7; k++) begin
            @(posedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_addr <= idx[k];
            i_cfg_wdata <= vals[k];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_up_mask = up;
        cfg_held_en = held;
        cfg_click_to = click_to;
        cfg_double_to = double_to;
        cfg_long_min = long_min;
        cfg_rpt_start = rpt_start;
        cfg_rpt_gap = rpt_gap;
    endtask

    function automatic logic [31:0] pick_duration();
        case ($urandom_range(0, 7))
            0: return cfg_click_to - 1;
            1: return cfg_click_to;
            2: return cfg_long_min;
            3: return cfg_long_min + 1;
            4: return $urandom_range(0, 1500);
            5: return $urandom;
            default: return $urandom_range(0, 300);
        endcase
    endfunction

    function automatic logic [31:0] pick_gap();
        case ($urandom_range(0, 5))
            0, 1, 2: return $urandom_range(0, 200);
            3: return cfg_double_to;
            4: return $urandom_range(0, 5000);
            default: return $urandom;
        endcase
    endfunction

    // press, some held checks, release: a well-formed gesture on one button
    task automatic gesture(input logic [btncc_pkg::IDX_W-1:0] b);
        logic                         up;
        logic [btncc_pkg::TICK_W-1:0] t0;
        logic [btncc_pkg::TICK_W-1:0] off;
        int                           n;
        int                           k;
        up = cfg_up_mask[b];
        tick = tick + pick_gap();
        t0 = tick;
        add_beat(btncc_pkg::CMD_LEVEL, b, ~up, t0);
        n = $urandom_range(0, 4);
        for (k = 0; k < n; k++) begin
            case ($urandom_range(0, 3))
                0: off = cfg_rpt_start + k * cfg_rpt_gap - 1;
                1: off = cfg_rpt_start + k * cfg_rpt_gap;
                2: off = cfg_rpt_start + k * cfg_rpt_gap + 1;
                default: off = $urandom_range(0, 3000);
            endcase
            add_beat(btncc_pkg::CMD_HELD, b, 1'($urandom_range(0, 1)), t0 + off);
        end
        tick = t0 + pick_duration();
        if ($urandom_range(0, 4) == 0)
            add_beat(btncc_pkg::CMD_LEVEL, b, ~up, tick);
        add_beat(btncc_pkg::CMD_LEVEL, b, up, tick);
    endtask

    task automatic random_phase(input int count, input int noise_pct);
        int target;
        target = beats_queued + count;
        while (beats_queued < target) begin
            if ($urandom_range(99) < noise_pct)
                add_beat(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                         1'($urandom_range(0, 1)),
                         $urandom_range(0, 1) ? $urandom : tick + $urandom_range(0, 2000));
            else
                gesture(3'($urandom_range(0, 7)));
        end
    endtask

    // stimulus sequence
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part on reset settings: released level 1, repeats off
        gap_pct_in = 20;
        gap_pct_out = 20;
        add_beat(btncc_pkg::CMD_HELD,  3'd0, 1'b0, 32'd0);     // held check before first event
        add_beat(btncc_pkg::CMD_LEVEL, 3'd0, 1'b1, 32'd0);     // first event is a release
        add_beat(btncc_pkg::CMD_LEVEL, 3'd0, 1'b1, 32'd5);     // unchanged level
        add_beat(btncc_pkg::CMD_LEVEL, 3'd0, 1'b0, 32'd10);    // press
        add_beat(btncc_pkg::CMD_HELD,  3'd0, 1'b1, 32'd2000);  // repeats disabled
        add_beat(btncc_pkg::CMD_LEVEL, 3'd0, 1'b0, 32'd20);    // unchanged while down
        add_beat(btncc_pkg::CMD_LEVEL, 3'd0, 1'b1, 32'd100);   // first click close to tick zero
        add_beat(btncc_pkg::CMD_LEVEL, 3'd0, 1'b0, 32'd200);
        add_beat(btncc_pkg::CMD_LEVEL, 3'd0, 1'b1, 32'd300);   // double click
        add_beat(btncc_pkg::CMD_LEVEL, 3'd7, 1'b0, 32'hFFFF_FFFF);  // first event is a press
        add_beat(btncc_pkg::CMD_LEVEL, 3'd7, 1'b1, 32'd4000);  // long click across the wrap
        add_beat(btncc_pkg::CMD_LEVEL, 3'd7, 1'b0, 32'd5000);
        add_beat(btncc_pkg::CMD_LEVEL, 3'd7, 1'b1, 32'd5500);  // exactly the click timeout
        add_beat(btncc_pkg::CMD_LEVEL, 3'd7, 1'b0, 32'd6000);
        add_beat(btncc_pkg::CMD_LEVEL, 3'd7, 1'b1, 32'd7001);  // just over long click minimum
        add_beat(btncc_pkg::CMD_LEVEL, 3'd7, 1'b0, 32'd10000);
        add_beat(btncc_pkg::CMD_LEVEL, 3'd7, 1'b1, 32'd11000); // exactly long click minimum
        add_beat(btncc_pkg::CMD_LEVEL, 3'd3, 1'b0, 32'h8000_0000);
        add_beat(btncc_pkg::CMD_HELD,  3'd3, 1'b0, 32'h8000_1000);
        add_beat(btncc_pkg::CMD_LEVEL, 3'd3, 1'b1, 32'h8000_01F3);  // click, no double
        add_beat(btncc_pkg::CMD_HELD,  3'd5, 1'b1, 32'h7FFF_FFFF);
        drain_pipe();

        // typical settings, released level 1, all repeats on, with gaps
        set_config(8'hFF, 8'hFF, 32'd500, 32'd400, 32'd1000, 32'd1000, 32'd200);
        tick = '0;
        gap_pct_in = 25;
        gap_pct_out = 25;
        random_phase(400, 15);
        drain_pipe();

        // all thresholds zero, released level 0
        set_config(8'h00, 8'hFF, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        gap_pct_in = 0;
        gap_pct_out = 25;
        random_phase(250, 15);
        drain_pipe();

        // all thresholds at maximum
        set_config(8'hA5, 8'h5A, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF);
        gap_pct_in = 25;
        gap_pct_out = 0;
        random_phase(250, 15);
        drain_pipe();

        // random settings, each phase starting just below the tick wrap or at a random tick
        repeat (3) begin
            set_config(8'($urandom), 8'($urandom), $urandom_range(0, 1500),
                       $urandom_range(0, 1500), $urandom_range(0, 2000),
                       $urandom_range(0, 2000), $urandom_range(0, 500));
            tick = $urandom_range(0, 1) ? 32'hFFFF_F000 : $urandom;
            gap_pct_in = 20;
            gap_pct_out = 20;
            random_phase(250, 20);
            drain_pipe();
        end

        // closing stretch at full rate
        set_config(8'h3C, 8'hFF, 32'd500, 32'd400, 32'd1000, 32'd800, 32'd150);
        gap_pct_in = 0;
        gap_pct_out = 0;
        random_phase(300, 10);
        drain_pipe();
        repeat (8) @(posedge i_clk);

        if (flags_due.size() != 0) begin
            $error("%0d expected results never arrived", flags_due.size());
            mismatches++;
        end
        $display("sent %0d beats, checked %0d results, %0d mismatches",
                 beats_taken, results_seen, mismatches);
        $display("seen: %0d presses, %0d clicks, %0d double, %0d long, %0d repeats",
                 n_press, n_click, n_double, n_long, n_repeat);
        if (mismatches == 0)
            $display("PASS button_click_classifier_top");
        else
            $display("FAIL button_click_classifier_top");
        $finish;
    end

endmodule
